>>> rtl/core/patbl_pkg.sv
package patbl_pkg;

	localparam int TABLE_SLOTS_DEF  = 4096;
	localparam int PROBE_WINDOW_DEF = 32;
	localparam int TOKEN_SCALE_DEF  = 1000;

	localparam int CFG_W     = 32;
	localparam int SLOTCNT_W = 13;

	localparam logic [63:0] HASH_BASIS   = 64'hcbf29ce484222325;
	localparam logic [8:0]  HASH_PRIME_LO = 9'h1b3;
	localparam int          HASH_PRIME_SH = 40;
	localparam logic [7:0]  TAG_V4 = 8'd2;
	localparam logic [7:0]  TAG_V6 = 8'd10;
	localparam logic [31:0] V4_MAPPED_MARK = 32'h0000ffff;

	localparam logic [1:0] REG_SLOT_COUNT = 2'd0;
	localparam logic [1:0] REG_REFILL     = 2'd1;
	localparam logic [1:0] REG_PERIOD     = 2'd2;
	localparam logic [1:0] REG_BURST      = 2'd3;

	localparam logic [1:0] VERDICT_ALLOW    = 2'd0;
	localparam logic [1:0] VERDICT_DENY     = 2'd1;
	localparam logic [1:0] VERDICT_BYPASS   = 2'd2;
	localparam logic [1:0] VERDICT_OVERFLOW = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_MOD_GO,
		S_MOD_WAIT,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_MUL,
		S_DIV_GO,
		S_DIV_WAIT,
		S_UPDATE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
		logic [31:0] remainder;
	} div_rsp_t;

endpackage

>>> rtl/core/per_address_token_bucket_limiter.sv
// per-address token bucket limiter
// input channel: in_valid/in_stall carries addr_family, addr_high, addr_low and
// now_ms; a beat is taken when in_valid is high and in_stall is low.
// output channel: out_valid/out_stall carries verdict and overflow_total, one
// result beat for each input beat, in order.
// configuration: cfg_we writes cfg_data into register cfg_index (0 slot count,
// 1 refill per period, 2 period in ms, 3 burst capacity); the user is to write
// only while idle, the block itself does not enforce it. one request at a
// time: the address is hashed one byte a cycle (5 or 9 bytes), the home slot
// comes from a 64-step bit-serial divider, each probe of the window is a read
// and a check of the slot memory, and the refill takes a multiply state and
// a second divider pass. a bypassed request goes from idle straight to the
// result; a new request can be taken in the cycle after the result is loaded.
// after reset all TABLE_SLOTS slots of the slot memory are cleared one slot a
// cycle, with in_stall high; configuration writes are taken during that pass.
// the result and the overflow total sit in an output register; while
// out_stall holds it, the next request may be accepted and is worked on, but
// its result waits until the register is free.
module per_address_token_bucket_limiter #(
	parameter int TABLE_SLOTS  = patbl_pkg::TABLE_SLOTS_DEF,
	parameter int PROBE_WINDOW = patbl_pkg::PROBE_WINDOW_DEF,
	parameter int TOKEN_SCALE  = patbl_pkg::TOKEN_SCALE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  addr_family,
	input  logic [63:0] addr_high,
	input  logic [63:0] addr_low,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  verdict,
	output logic [63:0] overflow_total
);
	import patbl_pkg::*;

	localparam int IW  = $clog2(TABLE_SLOTS);
	localparam int NW  = (IW + 1 > SLOTCNT_W) ? IW + 1 : SLOTCNT_W;
	localparam int PWW = $clog2(PROBE_WINDOW + 1);

	state_t state_q, state_d;

	logic [SLOTCNT_W-1:0] slot_count_q;
	logic [31:0] refill_q, period_q, burst_q;
	logic [63:0] ovf_q;
	logic [63:0] ovf_out_q;
	logic        out_valid_q;
	logic [1:0]  verdict_q;
	logic [IW-1:0] clr_q;

	logic [63:0] hash_q;
	logic [71:0] bytes_q;
	logic [3:0]  cnt_q;
	logic [31:0] now_q;
	logic [IW-1:0] cur_q, slot_q, victim_q;
	logic        victim_ok_q;
	logic [31:0] best_q;
	logic [PWW-1:0] probe_q;
	logic [63:0] word_q;
	logic [63:0] prod_q;
	logic [1:0]  res_q;

	logic [SLOTCNT_W-1:0] n;
	logic        bypass, mapped, accept, out_load;
	logic [63:0] hx, hmul, hash_fix;
	logic [127:0] rd_data, wr_data;
	logic        rd_en, wr_en;
	logic [IW-1:0] wr_addr;
	logic [63:0] key_r, bkt_r;
	logic [31:0] age, elapsed;
	logic        cand, hit, last_probe, vic_any;
	logic [IW-1:0] vic_idx, cur_next;
	logic [NW-1:0] cur_inc;
	logic [64:0] sum;
	logic [31:0] capped, tok_new, stamp_new;
	logic        allow;
	div_req_t    dreq;
	div_rsp_t    drsp;

	assign n = (32'(slot_count_q) > 32'(TABLE_SLOTS)) ? SLOTCNT_W'(TABLE_SLOTS) : slot_count_q;
	assign bypass = addr_family[1] || n == '0 || period_q == '0 || burst_q == '0;
	assign mapped = addr_family == 2'd1 && addr_high == '0 && addr_low[63:32] == V4_MAPPED_MARK;
	assign accept = in_valid && !in_stall;
	assign out_load = state_q == S_OUT && (!out_valid_q || !out_stall);

	assign hx       = hash_q ^ {56'b0, bytes_q[71:64]};
	assign hmul     = (hx << HASH_PRIME_SH) + (hx * 64'(HASH_PRIME_LO));
	assign hash_fix = (hash_q == '0) ? 64'd1 : hash_q;

	assign key_r   = rd_data[127:64];
	assign bkt_r   = rd_data[63:0];
	assign age     = now_q - bkt_r[63:32];
	assign cand    = bkt_r != '0 && age != '0 && !age[31] && age > best_q;
	assign hit     = key_r == '0 || key_r == hash_q;
	assign last_probe = probe_q == PWW'(PROBE_WINDOW - 1);
	assign vic_any = victim_ok_q || cand;
	assign vic_idx = cand ? cur_q : victim_q;
	assign cur_inc = NW'(cur_q) + NW'(1);
	assign cur_next = (cur_inc >= NW'(n)) ? '0 : cur_inc[IW-1:0];

	assign elapsed   = now_q - word_q[63:32];
	assign sum       = {33'b0, word_q[31:0]} + {1'b0, drsp.quotient};
	assign capped    = (sum > {33'b0, burst_q}) ? burst_q : sum[31:0];
	assign allow     = capped >= 32'(TOKEN_SCALE);
	assign tok_new   = allow ? capped - 32'(TOKEN_SCALE) : capped;
	assign stamp_new = (drsp.quotient != '0) ? now_q : word_q[63:32];

	assign dreq.start    = state_q == S_MOD_GO || state_q == S_DIV_GO;
	assign dreq.dividend = (state_q == S_MOD_GO) ? hash_fix : prod_q;
	assign dreq.divisor  = (state_q == S_MOD_GO) ? 32'(n) : period_q;

	assign rd_en   = state_q == S_PROBE_RD;
	assign wr_en   = state_q == S_CLEAR || state_q == S_UPDATE;
	assign wr_addr = (state_q == S_CLEAR) ? clr_q : slot_q;
	assign wr_data = (state_q == S_CLEAR) ? '0 : {hash_q, stamp_new, tok_new};

	patbl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	patbl_table #(
		.DEPTH (TABLE_SLOTS),
		.AW    (IW)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (cur_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = state_q != S_IDLE;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == IW'(TABLE_SLOTS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = bypass ? S_OUT : S_HASH;
			end
			S_HASH: begin
				if (cnt_q == 4'd1) state_d = S_MOD_GO;
			end
			S_MOD_GO: state_d = S_MOD_WAIT;
			S_MOD_WAIT: begin
				if (drsp.done) state_d = S_PROBE_RD;
			end
			S_PROBE_RD: state_d = S_PROBE_CHK;
			S_PROBE_CHK: begin
				if (hit) state_d = S_MUL;
				else if (!last_probe) state_d = S_PROBE_RD;
				else state_d = vic_any ? S_MUL : S_OUT;
			end
			S_MUL: state_d = S_DIV_GO;
			S_DIV_GO: state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (drsp.done) state_d = S_UPDATE;
			end
			S_UPDATE: state_d = S_OUT;
			S_OUT: begin
				if (!out_valid_q || !out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOTCNT_W'(4096);
			refill_q     <= 32'd1000;
			period_q     <= 32'd1000;
			burst_q      <= 32'd1000;
			ovf_q        <= '0;
			ovf_out_q    <= '0;
			out_valid_q  <= 1'b0;
			clr_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SLOT_COUNT: slot_count_q <= cfg_data[SLOTCNT_W-1:0];
					REG_REFILL:     refill_q     <= cfg_data;
					REG_PERIOD:     period_q     <= cfg_data;
					REG_BURST:      burst_q      <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_CLEAR) clr_q <= clr_q + IW'(1);
			if (state_q == S_PROBE_CHK && !hit && last_probe && !vic_any) ovf_q <= ovf_q + 64'd1;
			if (out_load) ovf_out_q <= ovf_q;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				now_q       <= now_ms;
				hash_q      <= HASH_BASIS;
				best_q      <= period_q;
				victim_ok_q <= 1'b0;
				probe_q     <= '0;
				res_q       <= VERDICT_BYPASS;
				if (addr_family == 2'd0 || mapped) begin
					bytes_q <= {TAG_V4, addr_low[31:0], 32'b0};
					cnt_q   <= 4'd5;
				end else begin
					bytes_q <= {TAG_V6, addr_high};
					cnt_q   <= 4'd9;
				end
			end
			S_HASH: begin
				hash_q  <= hmul;
				bytes_q <= {bytes_q[63:0], 8'b0};
				cnt_q   <= cnt_q - 4'd1;
			end
			S_MOD_GO: hash_q <= hash_fix;
			S_MOD_WAIT: cur_q <= drsp.remainder[IW-1:0];
			S_PROBE_CHK: begin
				if (hit) begin
					slot_q <= cur_q;
					word_q <= bkt_r;
				end else begin
					if (cand) begin
						best_q      <= age;
						victim_q    <= cur_q;
						victim_ok_q <= 1'b1;
					end
					probe_q <= probe_q + PWW'(1);
					cur_q   <= cur_next;
					slot_q  <= vic_idx;
					word_q  <= '0;
					res_q   <= VERDICT_OVERFLOW;
				end
			end
			S_MUL: prod_q <= {32'b0, elapsed} * {32'b0, refill_q};
			S_UPDATE: res_q <= allow ? VERDICT_ALLOW : VERDICT_DENY;
			default: ;
		endcase
		if (out_load) verdict_q <= res_q;
	end

	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign overflow_total = ovf_out_q;
endmodule

>>> rtl/core/patbl_div.sv
module patbl_div (
	input  logic                clk,
	input  logic                arst_n,
	input  patbl_pkg::div_req_t req,
	output patbl_pkg::div_rsp_t rsp
);
	import patbl_pkg::*;

	logic [63:0] dq_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [32:0] shifted;
	logic        ge;

	assign shifted = {rem_q, dq_q[63]};
	assign ge      = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 7'd1);
			if (req.start) begin
				cnt_q <= 7'd64;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dq_q  <= {dq_q[62:0], ge};
			rem_q <= ge ? 32'(shifted - {1'b0, div_q}) : shifted[31:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dq_q;
	assign rsp.remainder = rem_q;
endmodule

>>> rtl/core/patbl_table.sv
module patbl_table #(
	parameter int DEPTH = patbl_pkg::TABLE_SLOTS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [127:0]  rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [127:0]  wr_data
);
	logic [127:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

>>> rtl/core/patbl_checker.sv
module patbl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  verdict,
	input logic [63:0] overflow_total
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(overflow_total))
		else $error("stalled result beat changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a beat");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result beat without a request in work");
endmodule

bind per_address_token_bucket_limiter patbl_checker u_patbl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.verdict        (verdict),
	.overflow_total (overflow_total)
);
